@@ src/pn2d_pkg.sv @@
// shared types, function codes and the fade curve table for the 2d gradient noise block
package pn2d_pkg;

    localparam int FUNC_W        = 2;
    localparam int ENTRY_W       = 8;
    localparam int PERM_W        = 8;
    localparam int GRAD_W        = 16;
    localparam int NOISE_W       = 16;
    localparam int FADE_W        = 15;
    localparam int FADE_ENTRIES  = 256;
    localparam int FADE_IDX_W    = 8;
    localparam int WEIGHT_FRAC   = 15;

    localparam int TABLE_SIZE_DEF    = 256;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int SAMPLE_BITS_DEF   = 16;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_PERM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_GRAD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL      = 2'd2;

    // 255^5 and its half for rounding
    localparam longint unsigned FADE_DEN      = 64'd1078203909375;
    localparam longint unsigned FADE_DEN_HALF = FADE_DEN / 64'd2;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gx;
    } t_grad;

    typedef logic [FADE_ENTRIES-1:0][FADE_W-1:0] t_fade_rom;

    // 6t^5 - 15t^4 + 10t^3 at t = i/255, unsigned q0.15, rounded half up, clamped
    function automatic t_fade_rom build_fade_rom();
        t_fade_rom       rom;
        longint unsigned li;
        longint unsigned poly;
        longint unsigned num;
        longint unsigned q;
        for (int i = 0; i < FADE_ENTRIES; i++) begin
            li   = 64'(i);
            poly = 64'd6 * li * li + 64'd650250 - 64'd3825 * li;
            num  = li * li * li * poly;
            q    = (num * 64'd32768 + FADE_DEN_HALF) / FADE_DEN;
            rom[i] = (q > 64'd32767) ? 15'h7fff : q[FADE_W-1:0];
        end
        return rom;
    endfunction

    localparam t_fade_rom FADE_ROM = build_fade_rom();

endpackage

@@ src/pn2d_blend.sv @@
// corner dot products, two levels of weighted blend and output saturation
module pn2d_blend
    import pn2d_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_grad [3:0]               i_grad,
    input  logic [FRACTION_BITS-1:0]  i_fx,
    input  logic [FRACTION_BITS-1:0]  i_fy,
    input  logic [FADE_W-1:0]         i_u,
    input  logic [FADE_W-1:0]         i_v,
    output logic                      o_valid,
    output logic signed [NOISE_W-1:0] o_noise
);

    localparam int FB   = FRACTION_BITS;
    localparam int PW   = GRAD_W + FB + 1;
    localparam int DSW  = PW + 1;
    localparam int DOTW = DSW - FB;
    localparam int L1D  = DOTW + 1;
    localparam int MW1  = L1D + FADE_W + 1;
    localparam int L1W  = MW1 - WEIGHT_FRAC + 1;
    localparam int L2D  = L1W + 1;
    localparam int MW2  = L2D + FADE_W + 1;
    localparam int L2W  = MW2 - WEIGHT_FRAC + 1;

    localparam logic signed [DSW-1:0] RND_D  = DSW'(1) << (FB - 1);
    localparam logic signed [MW1-1:0] RND_W1 = MW1'(1) << (WEIGHT_FRAC - 1);
    localparam logic signed [MW2-1:0] RND_W2 = MW2'(1) << (WEIGHT_FRAC - 1);

    logic [7:0]                  r_vld;
    logic [2:0][FADE_W-1:0]      r_u;
    logic [5:0][FADE_W-1:0]      r_v;

    logic signed [FB:0]          dx0, dx1, dy0, dy1;
    logic signed [PW-1:0]        n_px [4];
    logic signed [PW-1:0]        n_py [4];
    logic signed [PW-1:0]        r_px [4];
    logic signed [PW-1:0]        r_py [4];
    logic signed [DSW-1:0]       dsum [4];
    logic signed [DOTW-1:0]      n_dot [4];
    logic signed [DOTW-1:0]      r_dot [4];

    logic signed [L1D-1:0]       n_d1, n_d2, r_d1, r_d2;
    logic signed [DOTW-1:0]      r_a1, r_a2, r_a1b, r_a2b;
    logic signed [MW1-1:0]       n_m1, n_m2, r_m1, r_m2;
    logic signed [MW1-1:0]       ms1, ms2;
    logic signed [L1W-1:0]       n_x1, n_x2, r_x1, r_x2, r_x1b, r_x1c;
    logic signed [L2D-1:0]       n_dv, r_dv;
    logic signed [MW2-1:0]       n_mv, r_mv, msv;
    logic signed [L2W-1:0]       n_sum;
    logic signed [NOISE_W-1:0]   n_noise, r_noise;

    assign dx0 = {1'b0, i_fx};
    assign dx1 = {1'b1, i_fx};
    assign dy0 = {1'b0, i_fy};
    assign dy1 = {1'b1, i_fy};

    // corner k: bit 0 selects the right column, bit 1 the upper row
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_px[k] = PW'(i_grad[k].gx) * PW'(k[0] ? dx1 : dx0);
            n_py[k] = PW'(i_grad[k].gy) * PW'(k[1] ? dy1 : dy0);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dsum[k]  = DSW'(r_px[k]) + DSW'(r_py[k]) + RND_D;
            n_dot[k] = dsum[k][DSW-1:FB];
        end
    end

    assign n_d1 = L1D'(r_dot[1]) - L1D'(r_dot[0]);
    assign n_d2 = L1D'(r_dot[3]) - L1D'(r_dot[2]);

    assign n_m1 = MW1'(r_d1) * MW1'(signed'({1'b0, r_u[2]}));
    assign n_m2 = MW1'(r_d2) * MW1'(signed'({1'b0, r_u[2]}));

    assign ms1  = r_m1 + RND_W1;
    assign ms2  = r_m2 + RND_W1;
    assign n_x1 = L1W'(r_a1b) + L1W'(signed'(ms1[MW1-1:WEIGHT_FRAC]));
    assign n_x2 = L1W'(r_a2b) + L1W'(signed'(ms2[MW1-1:WEIGHT_FRAC]));

    assign n_dv = L2D'(r_x2) - L2D'(r_x1);
    assign n_mv = MW2'(r_dv) * MW2'(signed'({1'b0, r_v[5]}));

    assign msv   = r_mv + RND_W2;
    assign n_sum = L2W'(r_x1c) + L2W'(signed'(msv[MW2-1:WEIGHT_FRAC]));

    always_comb begin
        if ((&n_sum[L2W-1:NOISE_W-1]) || (~|n_sum[L2W-1:NOISE_W-1])) begin
            n_noise = n_sum[NOISE_W-1:0];
        end else if (n_sum[L2W-1]) begin
            n_noise = {1'b1, {(NOISE_W-1){1'b0}}};
        end else begin
            n_noise = {1'b0, {(NOISE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= {r_u[1:0], i_u};
        r_v <= {r_v[4:0], i_v};
        for (int k = 0; k < 4; k++) begin
            r_px[k]  <= n_px[k];
            r_py[k]  <= n_py[k];
            r_dot[k] <= n_dot[k];
        end
        r_d1    <= n_d1;
        r_d2    <= n_d2;
        r_a1    <= r_dot[0];
        r_a2    <= r_dot[2];
        r_m1    <= n_m1;
        r_m2    <= n_m2;
        r_a1b   <= r_a1;
        r_a2b   <= r_a2;
        r_x1    <= n_x1;
        r_x2    <= n_x2;
        r_dv    <= n_dv;
        r_x1b   <= r_x1;
        r_mv    <= n_mv;
        r_x1c   <= r_x1b;
        r_noise <= n_noise;
    end

    assign o_valid = r_vld[7];
    assign o_noise = r_noise;

endmodule

@@ src/perlin_noise_2d_eval.sv @@
// top level of the 2d gradient noise evaluator: table memories, hashing and result port
//
// The block takes one word per clock and never raises busy. A load word writes
// one permutation or gradient entry and gives no result; it takes effect for
// every evaluate word accepted after it. An evaluate word gives one noise word
// on o_noise_value with o_strobe high for one cycle; results leave in the order
// the words came in and the receiver cannot hold them off. The path is three
// synchronous memory reads in a row (cell hash, corner hash, gradient fetch)
// followed by the dot product and blend multipliers. The tables are kept in
// replicated copies, one for the cell hash read and two each for the corner
// hash and gradient reads, so each copy reads two entries a cycle and every
// load reaches each copy at that copy's stage. There is no clearing pass:
// tables must be loaded before they are used.
module perlin_noise_2d_eval
    import pn2d_pkg::*;
#(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [ENTRY_W-1:0]        i_entry_index,
    input  logic [PERM_W-1:0]         i_perm_value,
    input  logic signed [GRAD_W-1:0]  i_grad_x,
    input  logic signed [GRAD_W-1:0]  i_grad_y,
    input  logic signed [SAMPLE_BITS-1:0] i_coord_x,
    input  logic signed [SAMPLE_BITS-1:0] i_coord_y,
    output logic                      o_strobe,
    output logic signed [NOISE_W-1:0] o_noise_value
);

    localparam int IDXW     = $clog2(TABLE_SIZE);
    localparam int FB       = FRACTION_BITS;
    localparam int SB       = SAMPLE_BITS;
    localparam int PIPE_LAT = 11;

    logic                     accept;
    logic                     s0_eval, s0_ldp, s0_ldg;
    logic signed [SB+IDXW-1:0] cx_ext, cy_ext;
    logic [IDXW-1:0]          s0_xi, s0_xi1, s0_yi, s0_idx;

    logic                     r_s1_eval, r_s1_ldp, r_s1_ldg;
    logic                     r_s2_eval, r_s2_ldg;
    logic                     r_s3_eval;

    logic [IDXW-1:0]          r_s1_yi, r_s1_idx, r_s2_idx;
    logic [FB-1:0]            r_s1_fx, r_s1_fy, r_s2_fx, r_s2_fy, r_s3_fx, r_s3_fy;
    logic [PERM_W-1:0]        r_s1_perm;
    t_grad                    r_s1_grad, r_s2_grad;
    logic [FADE_W-1:0]        r_s3_u, r_s3_v;

    logic [PERM_W-1:0]        mem_perm_a [TABLE_SIZE];
    logic [PERM_W-1:0]        mem_perm_b [TABLE_SIZE];
    logic [PERM_W-1:0]        mem_perm_c [TABLE_SIZE];
    t_grad                    mem_grad_d [TABLE_SIZE];
    t_grad                    mem_grad_e [TABLE_SIZE];

    logic [PERM_W-1:0]        r_pa, r_pb;
    logic [PERM_W-1:0]        r_h00, r_h01, r_h10, r_h11;
    t_grad [3:0]              r_grad;

    logic [IDXW-1:0]          s1_a, s1_a1, s1_b, s1_b1;
    logic [FB+FADE_IDX_W-1:0] s2_fxp, s2_fyp;
    logic [FADE_W-1:0]        n_u, n_v;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        s0_ldp  = 1'b0;
        s0_ldg  = 1'b0;
        s0_eval = 1'b0;
        unique case (i_func)
            FUNC_LOAD_PERM: s0_ldp  = accept;
            FUNC_LOAD_GRAD: s0_ldg  = accept;
            FUNC_EVAL:      s0_eval = accept;
            default: ;
        endcase
    end

    // floor of the coordinate, wrapped to the table
    assign cx_ext = {{IDXW{i_coord_x[SB-1]}}, i_coord_x};
    assign cy_ext = {{IDXW{i_coord_y[SB-1]}}, i_coord_y};
    assign s0_xi  = cx_ext[FB+IDXW-1:FB];
    assign s0_yi  = cy_ext[FB+IDXW-1:FB];
    assign s0_xi1 = s0_xi + IDXW'(1);
    assign s0_idx = IDXW'(i_entry_index);

    assign s1_a  = IDXW'(r_pa) + r_s1_yi;
    assign s1_b  = IDXW'(r_pb) + r_s1_yi;
    assign s1_a1 = s1_a + IDXW'(1);
    assign s1_b1 = s1_b + IDXW'(1);

    // fade index floor(frac * 255 / 2^fb)
    assign s2_fxp = {r_s2_fx, FADE_IDX_W'(0)} - {FADE_IDX_W'(0), r_s2_fx};
    assign s2_fyp = {r_s2_fy, FADE_IDX_W'(0)} - {FADE_IDX_W'(0), r_s2_fy};
    assign n_u    = FADE_ROM[s2_fxp[FB+FADE_IDX_W-1:FB]];
    assign n_v    = FADE_ROM[s2_fyp[FB+FADE_IDX_W-1:FB]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_eval <= 1'b0;
            r_s1_ldp  <= 1'b0;
            r_s1_ldg  <= 1'b0;
            r_s2_eval <= 1'b0;
            r_s2_ldg  <= 1'b0;
            r_s3_eval <= 1'b0;
        end else begin
            r_s1_eval <= s0_eval;
            r_s1_ldp  <= s0_ldp;
            r_s1_ldg  <= s0_ldg;
            r_s2_eval <= r_s1_eval;
            r_s2_ldg  <= r_s1_ldg;
            r_s3_eval <= r_s2_eval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_yi   <= s0_yi;
        r_s1_fx   <= i_coord_x[FB-1:0];
        r_s1_fy   <= i_coord_y[FB-1:0];
        r_s1_idx  <= s0_idx;
        r_s1_perm <= i_perm_value;
        r_s1_grad <= '{gy: i_grad_y, gx: i_grad_x};
        r_s2_fx   <= r_s1_fx;
        r_s2_fy   <= r_s1_fy;
        r_s2_idx  <= r_s1_idx;
        r_s2_grad <= r_s1_grad;
        r_s3_fx   <= r_s2_fx;
        r_s3_fy   <= r_s2_fy;
        r_s3_u    <= n_u;
        r_s3_v    <= n_v;
    end

    // cell hash copy
    always_ff @(posedge i_clk) begin
        if (s0_ldp) begin
            mem_perm_a[s0_idx] <= i_perm_value;
        end
        r_pa <= mem_perm_a[s0_xi];
        r_pb <= mem_perm_a[s0_xi1];
    end

    // corner hash copies
    always_ff @(posedge i_clk) begin
        if (r_s1_ldp) begin
            mem_perm_b[r_s1_idx] <= r_s1_perm;
            mem_perm_c[r_s1_idx] <= r_s1_perm;
        end
        r_h00 <= mem_perm_b[s1_a];
        r_h01 <= mem_perm_b[s1_a1];
        r_h10 <= mem_perm_c[s1_b];
        r_h11 <= mem_perm_c[s1_b1];
    end

    // gradient copies
    always_ff @(posedge i_clk) begin
        if (r_s2_ldg) begin
            mem_grad_d[r_s2_idx] <= r_s2_grad;
            mem_grad_e[r_s2_idx] <= r_s2_grad;
        end
        r_grad[0] <= mem_grad_d[IDXW'(r_h00)];
        r_grad[1] <= mem_grad_d[IDXW'(r_h10)];
        r_grad[2] <= mem_grad_e[IDXW'(r_h01)];
        r_grad[3] <= mem_grad_e[IDXW'(r_h11)];
    end

    pn2d_blend #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_eval),
        .i_grad  (r_grad),
        .i_fx    (r_s3_fx),
        .i_fy    (r_s3_fy),
        .i_u     (r_s3_u),
        .i_v     (r_s3_v),
        .o_valid (o_strobe),
        .o_noise (o_noise_value)
    );

    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_func == FUNC_EVAL, PIPE_LAT))
        else $error("noise word without an evaluate word");

    a_eval_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_EVAL) |-> ##PIPE_LAT o_strobe)
        else $error("evaluate word lost");

    a_zero_frac_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_eval && r_s3_fx == '0) |-> (r_s3_u == '0))
        else $error("fade weight not zero at cell corner");

endmodule
